FILE: rtl/sleep_table_wakeup_defines.svh
// Assertion macros for the sleep table block.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef SLEEP_TABLE_WAKEUP_DEFINES_SVH
`define SLEEP_TABLE_WAKEUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define STW_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define STW_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define STW_ASSERT_ALWAYS(lbl, expr)
`define STW_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

FILE: rtl/stw_pkg.sv
`timescale 1ns / 1ps

package stw_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ID_W   = 16;
  localparam int TICK_W = 63;

  localparam logic [TICK_W-1:0] TICK_ALL_ONES = '1;

  // Input kinds
  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // One sleeping thread
  typedef struct packed {
    logic [ID_W-1:0]   thread;
    logic [TICK_W-1:0] wakeup;
  } entry_t;

  // Common control for the row of cells
  typedef struct packed {
    logic   shift;
    entry_t wdata;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/stw_cell.sv
`timescale 1ns / 1ps

// One slot of the table: loads the write bus when selected,
// otherwise takes its upper neighbour's entry on a shift.
module stw_cell (
  input  logic               clk,
  input  stw_pkg::cell_ctl_t ctl,
  input  logic               sel,
  input  stw_pkg::entry_t    nbr,
  output stw_pkg::entry_t    q
);

  always_ff @(posedge clk) begin
    if (sel) begin
      q <= ctl.wdata;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule

FILE: rtl/stw_wake_q.sv
`timescale 1ns / 1ps

// Shifting queue of woken thread ids; pushed during the scan, popped
// from the head while the results go out. Push and pop never coincide.
module stw_wake_q (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      pop,
  input  logic [stw_pkg::ID_W-1:0]  wdata,
  output logic [stw_pkg::ID_W-1:0]  head,
  output logic                      empty,
  output logic                      one
);

  logic [stw_pkg::SLOTS-1:0][stw_pkg::ID_W-1:0] slot;
  logic [stw_pkg::CNT_W-1:0]                    cnt;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= cnt + stw_pkg::CNT_W'(1);
    end else if (pop) begin
      cnt <= cnt - stw_pkg::CNT_W'(1);
    end
  end

  // Storage: write at the tail, shift towards the head on pop
  always_ff @(posedge clk) begin
    if (push) begin
      slot[cnt[stw_pkg::IDX_W-1:0]] <= wdata;
    end else if (pop) begin
      slot <= {stw_pkg::ID_W'(0), slot[stw_pkg::SLOTS-1:1]};
    end
  end

  assign head  = slot[0];
  assign empty = (cnt == '0);
  assign one   = (cnt == stw_pkg::CNT_W'(1));

endmodule

FILE: rtl/sleep_table_wakeup.sv
`timescale 1ns / 1ps

// Sleep table with wakeup by tick. Sleeping threads sit in a row of
// SLOTS cells in arrival order. A sleep transfer (tuser 0) appends a
// thread and returns one result with the lowered earliest wakeup, or
// with table_full set when every slot is taken. A tick transfer
// (tuser 1) rotates the occupied entries through the head cell, one per
// cycle: due entries leave for the wake queue, the rest go back to the
// tail in order while the new earliest wakeup is found. A tick thus
// passes through the accept, a scan step per stored entry, a step to
// close the scan, and then max(1, w) results for w woken threads, one
// per cycle on the output while the output is not stalled. Every result
// of a tick carries the earliest wakeup after the whole tick, and only
// the final one has tlast.
// A new transfer is taken once the previous item's results have all been
// handed to the output register and that register is free or being read.
module sleep_table_wakeup (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // thread_id [15:0], tick_value [78:16], zero [79]
  input  logic        s_axis_tuser,  // action [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // woken_thread [15:0], next_wake [78:16], zero [79]
  output logic [1:0]  m_axis_tuser,  // woken_valid [0], table_full [1]
  output logic        m_axis_tlast   // last
);

  localparam int SLOTS  = stw_pkg::SLOTS;
  localparam int IDX_W  = stw_pkg::IDX_W;
  localparam int CNT_W  = stw_pkg::CNT_W;
  localparam int ID_W   = stw_pkg::ID_W;
  localparam int TICK_W = stw_pkg::TICK_W;

  stw_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  scan_left, scan_left_next;
  logic [CNT_W-1:0]  count_m1;
  logic [TICK_W-1:0] earliest, earliest_next;
  logic [TICK_W-1:0] best, best_next;
  logic [TICK_W-1:0] cur_tick, cur_tick_next;
  logic [TICK_W-1:0] lowered;

  // Output register
  logic              o_valid;
  logic              out_load;
  logic              out_free;
  logic              o_woken, o_woken_next;
  logic              o_full, o_full_next;
  logic              o_last, o_last_next;
  logic [ID_W-1:0]   o_thread, o_thread_next;
  logic [TICK_W-1:0] o_wake, o_wake_next;

  // Cell row
  stw_pkg::cell_ctl_t ctl;
  stw_pkg::entry_t    ent [SLOTS];
  stw_pkg::entry_t    head;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_pos;
  logic [SLOTS-1:0]   wr_sel;

  // Wake queue
  logic            q_push, q_pop, q_empty, q_one;
  logic [ID_W-1:0] q_head;

  logic            in_acc;
  logic [ID_W-1:0] in_id;
  logic [TICK_W-1:0] in_tick;

  assign in_id    = s_axis_tdata[15:0];
  assign in_tick  = s_axis_tdata[78:16];
  assign out_free = !o_valid || m_axis_tready;
  assign s_axis_tready = (state == stw_pkg::ST_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign head     = ent[0];
  assign count_m1 = count - CNT_W'(1);
  assign lowered  = (in_tick < earliest) ? in_tick : earliest;

  // Row of cells, each shifting towards the head
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      stw_pkg::entry_t nbr;
      if (gi < SLOTS - 1) begin : g_mid
        assign nbr = ent[gi+1];
      end else begin : g_end
        assign nbr = '0;
      end
      assign wr_sel[gi] = wr_en && (wr_pos == IDX_W'(gi));
      stw_cell u_cell (
        .clk (clk),
        .ctl (ctl),
        .sel (wr_sel[gi]),
        .nbr (nbr),
        .q   (ent[gi])
      );
    end
  endgenerate

  stw_wake_q u_wake_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .pop   (q_pop),
    .wdata (head.thread),
    .head  (q_head),
    .empty (q_empty),
    .one   (q_one)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= stw_pkg::ST_IDLE;
      count    <= '0;
      earliest <= stw_pkg::TICK_ALL_ONES;
    end else begin
      state    <= state_next;
      count    <= count_next;
      earliest <= earliest_next;
    end
  end

  // Scan working registers
  always_ff @(posedge clk) begin
    scan_left <= scan_left_next;
    best      <= best_next;
    cur_tick  <= cur_tick_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_woken  <= o_woken_next;
      o_full   <= o_full_next;
      o_last   <= o_last_next;
      o_thread <= o_thread_next;
      o_wake   <= o_wake_next;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next     = state;
    count_next     = count;
    earliest_next  = earliest;
    scan_left_next = scan_left;
    best_next      = best;
    cur_tick_next  = cur_tick;
    ctl.shift      = 1'b0;
    ctl.wdata      = head;
    wr_en          = 1'b0;
    wr_pos         = count_m1[IDX_W-1:0];
    q_push         = 1'b0;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    o_woken_next   = 1'b0;
    o_full_next    = 1'b0;
    o_last_next    = 1'b1;
    o_thread_next  = '0;
    o_wake_next    = earliest;

    case (state)
      stw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == stw_pkg::ACT_SLEEP) begin
            out_load = 1'b1;
            if (count == CNT_W'(SLOTS)) begin
              o_full_next = 1'b1;
            end else begin
              // append at the tail
              wr_en         = 1'b1;
              wr_pos        = count[IDX_W-1:0];
              ctl.wdata     = '{thread: in_id, wakeup: in_tick};
              count_next    = count + CNT_W'(1);
              earliest_next = lowered;
              o_wake_next   = lowered;
            end
          end else begin
            cur_tick_next  = in_tick;
            scan_left_next = count;
            best_next      = stw_pkg::TICK_ALL_ONES;
            state_next     = stw_pkg::ST_SCAN;
          end
        end
      end

      stw_pkg::ST_SCAN: begin
        if (scan_left != '0) begin
          // head leaves; kept entries re-enter behind the survivors
          ctl.shift      = 1'b1;
          scan_left_next = scan_left - CNT_W'(1);
          if (head.wakeup <= cur_tick) begin
            q_push     = 1'b1;
            count_next = count_m1;
          end else begin
            wr_en = 1'b1;
            if (head.wakeup < best) begin
              best_next = head.wakeup;
            end
          end
        end else begin
          earliest_next = best;
          state_next    = stw_pkg::ST_EMIT;
        end
      end

      stw_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (q_empty) begin
            state_next = stw_pkg::ST_IDLE;
          end else begin
            q_pop         = 1'b1;
            o_woken_next  = 1'b1;
            o_thread_next = q_head;
            o_last_next   = q_one;
            if (q_one) begin
              state_next = stw_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = stw_pkg::ST_IDLE;
      end
    endcase
  end

  // Ports
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {1'b0, o_wake, o_thread};
  assign m_axis_tuser  = {o_full, o_woken};
  assign m_axis_tlast  = o_last;

  // Checks
  `include "sleep_table_wakeup_defines.svh"

  `STW_ASSERT_ALWAYS(a_count_max, count <= CNT_W'(SLOTS))
  `STW_ASSERT_IMPLIES(a_empty_all_ones,
                      (state != stw_pkg::ST_SCAN) && (count == '0),
                      earliest == stw_pkg::TICK_ALL_ONES)
  `STW_ASSERT_IMPLIES(a_woken_not_full, o_valid && o_woken, !o_full)

endmodule
